>>> src/dpc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// DIB pixel converter package
// Shared constants, operation codes, register indexes and the divide-by-255
// helper used by the pixel converter.
// ============================================================================
package dpc_pkg;

    localparam int MAX_DIM_DEFAULT       = 512;
    localparam int PALETTE_DEPTH_DEFAULT = 256;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int COLOR_W   = 24;
    localparam int RAW_W     = 25;
    localparam int ADDR_W    = 18;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int DEPTH_W   = 3;
    localparam int SIZE_W    = 10;
    localparam int PCOUNT_W  = 9;
    localparam int PROD_W    = 16;

    localparam logic [OP_W-1:0] OP_PALETTE = 2'd0;
    localparam logic [OP_W-1:0] OP_PIXEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_REDO    = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd3;
    localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_PRESENT  = 3'd4;

    localparam logic [DEPTH_W-1:0]  RST_DEPTH_MODE    = DEPTH_32BPP;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH   = 10'd16;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT  = 10'd16;
    localparam logic [PCOUNT_W-1:0] RST_PALETTE_COUNT = 9'd256;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_PALETTE,
        SRC_STORE
    } t_src;

    // Exact floor(x / 255) for any product of two bytes.
    function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = (PROD_W+1)'(x) + (PROD_W+1)'(1) + (PROD_W+1)'(x[PROD_W-1:BYTE_W]);
        return s[PROD_W-1:BYTE_W];
    endfunction

endpackage

>>> src/dib_pixel_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// DIB pixel converter
// Turns icon bitmap pixels into premultiplied BGRA words with top-down
// addresses, using a palette memory and a pixel store for the redo pass.
// ============================================================================
// Pipeline: an accepted pixel or redo item passes stage registers A, B, C in turn.
// Throughput: one item per cycle while o_stall is low; the palette sees one
// access and the pixel store a read, plus a write for a 32 bpp pixel, at the edge that accepts the item.
// Reset: counters, flags and configuration return to their defaults at once;
// the palette and pixel store keep whatever they hold until written.
module dib_pixel_converter
    import dpc_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEFAULT,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [BYTE_W-1:0]    i_entry_index,
    input  logic [BYTE_W-1:0]    i_pixel_index,
    input  logic [BYTE_W-1:0]    i_blue,
    input  logic [BYTE_W-1:0]    i_green,
    input  logic [BYTE_W-1:0]    i_red,
    input  logic [BYTE_W-1:0]    i_alpha,
    input  logic                 i_mask_bit,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ADDR_W-1:0]    o_pixel_address,
    output logic [WORD_W-1:0]    o_pixel_word,
    output logic                 o_frame_done,
    output logic                 o_needs_redo
);

    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CNT_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int MUL_W       = 2 * DIM_W;
    localparam int PAL_AW      = $clog2(PALETTE_DEPTH);
    localparam logic [PCOUNT_W-1:0] PAL_LIMIT = PCOUNT_W'(PALETTE_DEPTH);
    localparam logic [SIZE_W:0]     DIM_LIMIT = (SIZE_W+1)'(MAX_DIM);

    logic [DEPTH_W-1:0]  r_depth_mode;
    logic [SIZE_W-1:0]   r_image_width;
    logic [SIZE_W-1:0]   r_image_height;
    logic [PCOUNT_W-1:0] r_palette_count;
    logic                r_mask_present;

    logic [CNT_W-1:0]    r_col, n_col;
    logic [CNT_W-1:0]    r_row, n_row;
    logic                r_seen_alpha, n_seen_alpha;
    logic [STORE_AW-1:0] r_redo_pos, n_redo_pos;

    logic [COLOR_W-1:0]  r_palette [PALETTE_DEPTH];
    logic [RAW_W-1:0]    r_pixel_store [STORE_DEPTH];
    logic [COLOR_W-1:0]  r_pal_q;
    logic [RAW_W-1:0]    r_raw_q;

    logic                r_a_v;
    t_src                r_a_src;
    logic [STORE_AW-1:0] r_a_addr;
    logic [BYTE_W-1:0]   r_a_blue, r_a_green, r_a_red, r_a_alpha;
    logic                r_a_done, r_a_redo;

    logic                r_b_v;
    logic [STORE_AW-1:0] r_b_addr;
    logic [PROD_W-1:0]   r_b_pb, r_b_pg, r_b_pr;
    logic [BYTE_W-1:0]   r_b_alpha;
    logic                r_b_done, r_b_redo;

    logic                r_c_v;
    logic [STORE_AW-1:0] r_c_addr;
    logic [WORD_W-1:0]   r_c_word;
    logic                r_c_done, r_c_redo;

    logic en0, en1, en2, accept, pass;
    logic is_pixel, is_redo, direct32, clear;
    logic [DIM_W-1:0]    w, h, wm1, hm1, col_c, row_c, mul_a;
    logic [MUL_W-1:0]    prod;
    logic [STORE_AW-1:0] pix_addr, last, redo_p;
    logic [PCOUNT_W-1:0] pal_lim;
    logic [BYTE_W-1:0]   idx, a_val;
    logic [PAL_AW-1:0]   pal_addr;
    logic                pal_we, store_we, done, redo;
    logic [STORE_AW-1:0] store_addr;
    t_src                src;

    logic [BYTE_W-1:0]   b_blue, b_green, b_red, b_alpha;

    assign en2     = !r_c_v || !i_stall;
    assign en1     = !r_b_v || en2;
    assign en0     = !r_a_v || en1;
    assign o_stall = !en0;
    assign accept  = i_valid && en0;

    assign is_pixel = (i_op == OP_PIXEL);
    assign is_redo  = (i_op == OP_REDO);
    assign pass     = accept && (is_pixel || is_redo);
    assign direct32 = (r_depth_mode >= DEPTH_32BPP);
    assign clear    = r_mask_present && i_mask_bit;

    always_comb begin
        if (r_image_width == '0) begin
            w = DIM_W'(1);
        end else if ({1'b0, r_image_width} > DIM_LIMIT) begin
            w = DIM_W'(MAX_DIM);
        end else begin
            w = DIM_W'(r_image_width);
        end
        if (r_image_height == '0) begin
            h = DIM_W'(1);
        end else if ({1'b0, r_image_height} > DIM_LIMIT) begin
            h = DIM_W'(MAX_DIM);
        end else begin
            h = DIM_W'(r_image_height);
        end
    end

    assign wm1   = w - DIM_W'(1);
    assign hm1   = h - DIM_W'(1);
    assign col_c = (DIM_W'(r_col) < wm1) ? DIM_W'(r_col) : wm1;
    assign row_c = (DIM_W'(r_row) < hm1) ? DIM_W'(r_row) : hm1;
    assign mul_a = is_redo ? h : (hm1 - row_c);
    assign prod  = MUL_W'(mul_a) * MUL_W'(w);

    assign pix_addr = STORE_AW'(prod + MUL_W'(col_c));
    assign last     = STORE_AW'(prod - MUL_W'(1));
    assign redo_p   = (r_redo_pos < last) ? r_redo_pos : last;

    always_comb begin
        pal_lim = (r_palette_count < PAL_LIMIT) ? r_palette_count : PAL_LIMIT;
        unique case (r_depth_mode)
            DEPTH_1BPP: idx = {7'd0, i_pixel_index[0]};
            DEPTH_4BPP: idx = {4'd0, i_pixel_index[3:0]};
            default:    idx = i_pixel_index;
        endcase
        if ({1'b0, idx} >= pal_lim) begin
            idx = '0;
        end
        pal_addr = (i_op == OP_PALETTE) ? PAL_AW'(i_entry_index) : PAL_AW'(idx);
    end

    always_comb begin
        if (direct32) begin
            src   = SRC_INPUT;
            a_val = i_alpha;
        end else if (r_depth_mode == DEPTH_24BPP) begin
            src   = SRC_INPUT;
            a_val = ALPHA_OPAQUE;
        end else begin
            src   = SRC_PALETTE;
            a_val = ALPHA_OPAQUE;
        end
        if (clear) begin
            a_val = '0;
        end
        if (is_redo) begin
            src = SRC_STORE;
        end
    end

    assign pal_we     = accept && (i_op == OP_PALETTE) && ({1'b0, i_entry_index} < PAL_LIMIT);
    assign store_we   = accept && is_pixel && direct32;
    assign store_addr = is_redo ? redo_p : pix_addr;

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_seen_alpha = r_seen_alpha;
        n_redo_pos   = r_redo_pos;
        done         = 1'b0;
        redo         = 1'b0;
        if (accept && is_pixel) begin
            if (DIM_W'(r_col) >= wm1) begin
                n_col = '0;
                if (DIM_W'(r_row) >= hm1) begin
                    done         = 1'b1;
                    redo         = direct32 && !r_seen_alpha && (a_val == '0);
                    n_row        = '0;
                    n_seen_alpha = 1'b0;
                    n_redo_pos   = '0;
                end else begin
                    n_row        = r_row + CNT_W'(1);
                    n_seen_alpha = r_seen_alpha || (direct32 && (a_val != '0));
                end
            end else begin
                n_col        = r_col + CNT_W'(1);
                n_seen_alpha = r_seen_alpha || (direct32 && (a_val != '0));
            end
        end else if (accept && is_redo) begin
            if (r_redo_pos >= last) begin
                done       = 1'b1;
                n_redo_pos = '0;
            end else begin
                n_redo_pos = r_redo_pos + STORE_AW'(1);
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode    <= RST_DEPTH_MODE;
            r_image_width   <= RST_IMAGE_WIDTH;
            r_image_height  <= RST_IMAGE_HEIGHT;
            r_palette_count <= RST_PALETTE_COUNT;
            r_mask_present  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEPTH_MODE:    r_depth_mode    <= i_cfg_data[DEPTH_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[SIZE_W-1:0];
                CFG_PALETTE_COUNT: r_palette_count <= i_cfg_data[PCOUNT_W-1:0];
                CFG_MASK_PRESENT:  r_mask_present  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_seen_alpha <= 1'b0;
            r_redo_pos   <= '0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_seen_alpha <= n_seen_alpha;
            r_redo_pos   <= n_redo_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[pal_addr] <= {i_red, i_green, i_blue};
        end
        if (pass) begin
            r_pal_q <= r_palette[pal_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_pixel_store[store_addr] <= {clear, i_red, i_green, i_blue};
        end
        if (pass) begin
            r_raw_q <= r_pixel_store[store_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en0) begin
            r_a_v <= pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pass) begin
            r_a_src   <= src;
            r_a_addr  <= is_redo ? redo_p : pix_addr;
            r_a_blue  <= i_blue;
            r_a_green <= i_green;
            r_a_red   <= i_red;
            r_a_alpha <= a_val;
            r_a_done  <= done;
            r_a_redo  <= redo;
        end
    end

    always_comb begin
        b_alpha = r_a_alpha;
        unique case (r_a_src)
            SRC_PALETTE: begin
                {b_red, b_green, b_blue} = r_pal_q;
            end
            SRC_STORE: begin
                {b_red, b_green, b_blue} = r_raw_q[COLOR_W-1:0];
                b_alpha = r_raw_q[COLOR_W] ? '0 : ALPHA_OPAQUE;
            end
            default: begin
                {b_red, b_green, b_blue} = {r_a_red, r_a_green, r_a_blue};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en1) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && r_a_v) begin
            r_b_addr  <= r_a_addr;
            r_b_pb    <= PROD_W'(b_blue) * PROD_W'(b_alpha);
            r_b_pg    <= PROD_W'(b_green) * PROD_W'(b_alpha);
            r_b_pr    <= PROD_W'(b_red) * PROD_W'(b_alpha);
            r_b_alpha <= b_alpha;
            r_b_done  <= r_a_done;
            r_b_redo  <= r_a_redo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en2) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_b_v) begin
            r_c_addr <= r_b_addr;
            r_c_word <= {r_b_alpha, div255(r_b_pr), div255(r_b_pg), div255(r_b_pb)};
            r_c_done <= r_b_done;
            r_c_redo <= r_b_redo;
        end
    end

    assign o_valid         = r_c_v;
    assign o_pixel_address = ADDR_W'(r_c_addr);
    assign o_pixel_word    = r_c_word;
    assign o_frame_done    = r_c_done;
    assign o_needs_redo    = r_c_redo;

    a_redo_with_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_needs_redo |-> o_frame_done)
        else $error("needs_redo raised without frame_done");

    a_redo_alpha_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_needs_redo |-> (o_pixel_word[WORD_W-1:WORD_W-BYTE_W] == '0))
        else $error("needs_redo raised on a pixel with nonzero alpha");

    a_full_pipe_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && r_b_v && r_c_v && i_stall |-> o_stall)
        else $error("item accepted while the pipeline is full and stalled");

    a_counters_clear_at_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_pixel && done |=> (r_col == '0) && (r_row == '0) && !r_seen_alpha)
        else $error("frame counters not cleared at frame end");

endmodule
